// File: sv/csml_pkg.sv
// ----------------------------------------------------------------------------
// csml_pkg
// Shared types and constants for the crosspoint switch map loader.
// ----------------------------------------------------------------------------
package csml_pkg;

  localparam int WORD_W         = 16;  // switch bits per map word
  localparam int SIG_COUNT      = 16;  // bus signals per chip
  localparam int CHIP_COUNT_DEF = 3;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  typedef enum logic [1:0] {
    ACT_CONNECT = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_UPDATE  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MODIFY,
    ST_LOAD,
    ST_SHIFT
  } state_t;

  // map memory control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } map_ctl_t;

  // serializer status back to the sequencer
  typedef struct packed {
    logic active;
    logic done;
  } ser_stat_t;

endpackage

// File: sv/crosspoint_switch_map_loader_core.sv
// ----------------------------------------------------------------------------
// crosspoint_switch_map_loader_core
// Switch map for chained 16x16 crosspoint chips: connect, clear-all and a
// bit-serial update that returns every map word in shift order.
// ----------------------------------------------------------------------------
//  channel   | handshake            | signals
//  ----------+----------------------+-----------------------------------------
//  command   | start & !busy        | action, pin_number, bus_signal
//  result    | strobe (one cycle)   | kind, accepted, pending, shift_word,
//            |                      | word_number, last_word
//
// Connect reads the map word, then writes it back with the switch bit set;
// clear-all and rejected connects are acknowledged straight from idle. Update
// reads and loads each map word in turn and shifts its 16 bits through the
// serializer. Reset empties the map at once through valid bits.
// Results cannot be stalled; busy is high while a command is in progress.
// ----------------------------------------------------------------------------
module crosspoint_switch_map_loader_core #(
  parameter int CHIP_COUNT = csml_pkg::CHIP_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [5:0]  pin_number,
  input  logic [4:0]  bus_signal,
  output logic        strobe,
  output logic        kind,
  output logic        accepted,
  output logic        pending,
  output logic [15:0] shift_word,
  output logic [5:0]  word_number,
  output logic        last_word
);

  localparam int MAP_WORDS = csml_pkg::WORD_W * CHIP_COUNT;
  localparam int AW        = $clog2(MAP_WORDS);

  csml_pkg::state_t    state, state_next;
  csml_pkg::map_ctl_t  mem_ctl;
  csml_pkg::ser_stat_t ser_stat;

  logic [AW-1:0]               rd_addr;
  logic [csml_pkg::WORD_W-1:0] rd_data;
  logic [csml_pkg::WORD_W-1:0] wr_data;
  logic [csml_pkg::WORD_W-1:0] ser_word;
  logic                        ser_load;

  logic [AW-1:0] cmd_idx;
  logic          cmd_ok;
  logic [AW-1:0] idx, idx_next;
  logic [3:0]    bit_sel, bit_sel_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          upd_pending, upd_pending_next;
  logic          is_last;

  logic        strobe_next, kind_next, accepted_next, pending_next, last_word_next;
  logic [15:0] shift_word_next;
  logic [5:0]  word_number_next;

  // decode pin and signal into a map word index
  assign cmd_ok  = ({1'b0, pin_number} < 7'(MAP_WORDS)) && !bus_signal[4];
  assign cmd_idx = AW'((CHIP_COUNT - 1 - int'(pin_number[5:4])) * csml_pkg::SIG_COUNT
                       + (csml_pkg::SIG_COUNT - 1 - int'(bus_signal[3:0])));
  assign is_last = (cnt == AW'(MAP_WORDS - 1));
  assign wr_data = rd_data | (csml_pkg::WORD_W'(1) << bit_sel);
  assign busy    = (state != csml_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    mem_ctl           = '0;
    rd_addr           = cmd_idx;
    ser_load          = 1'b0;
    idx_next          = idx;
    bit_sel_next      = bit_sel;
    cnt_next          = cnt;
    upd_pending_next  = upd_pending;
    strobe_next       = 1'b0;
    kind_next         = csml_pkg::KIND_ACK;
    accepted_next     = 1'b0;
    pending_next      = 1'b0;
    shift_word_next   = '0;
    word_number_next  = '0;
    last_word_next    = 1'b0;
    unique case (state)
      csml_pkg::ST_IDLE: begin
        if (start) begin
          unique case (action)
            csml_pkg::ACT_CONNECT: begin
              if (cmd_ok) begin
                mem_ctl.rd_en = 1'b1;
                idx_next      = cmd_idx;
                bit_sel_next  = pin_number[3:0];
                state_next    = csml_pkg::ST_MODIFY;
              end else begin
                // reject: acknowledge with the map untouched
                strobe_next  = 1'b1;
                pending_next = upd_pending;
              end
            end
            csml_pkg::ACT_CLEAR: begin
              mem_ctl.clear_all = 1'b1;
              upd_pending_next  = 1'b1;
              strobe_next       = 1'b1;
              accepted_next     = 1'b1;
              pending_next      = 1'b1;
            end
            csml_pkg::ACT_UPDATE: begin
              upd_pending_next = 1'b0;
              cnt_next         = '0;
              rd_addr          = '0;
              mem_ctl.rd_en    = 1'b1;
              state_next       = csml_pkg::ST_LOAD;
            end
            default: begin
              // unused action: drop it
            end
          endcase
        end
      end
      csml_pkg::ST_MODIFY: begin
        rd_addr          = idx;
        mem_ctl.wr_en    = 1'b1;
        upd_pending_next = 1'b1;
        strobe_next      = 1'b1;
        accepted_next    = 1'b1;
        pending_next     = 1'b1;
        state_next       = csml_pkg::ST_IDLE;
      end
      csml_pkg::ST_LOAD: begin
        rd_addr    = cnt;
        ser_load   = 1'b1;
        state_next = csml_pkg::ST_SHIFT;
      end
      csml_pkg::ST_SHIFT: begin
        rd_addr = cnt + 1'b1;
        if (ser_stat.done) begin
          strobe_next      = 1'b1;
          kind_next        = csml_pkg::KIND_WORD;
          shift_word_next  = ser_word;
          word_number_next = 6'(cnt);
          last_word_next   = is_last;
          if (is_last) begin
            state_next = csml_pkg::ST_IDLE;
          end else begin
            // advance to the next word
            mem_ctl.rd_en = 1'b1;
            cnt_next      = cnt + 1'b1;
            state_next    = csml_pkg::ST_LOAD;
          end
        end
      end
      default: state_next = csml_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    bit_sel     <= bit_sel_next;
    cnt         <= cnt_next;
    kind        <= kind_next;
    accepted    <= accepted_next;
    pending     <= pending_next;
    shift_word  <= shift_word_next;
    word_number <= word_number_next;
    last_word   <= last_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_pending <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      upd_pending <= upd_pending_next;
      strobe      <= strobe_next;
    end
  end

  csml_map_mem #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  csml_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (ser_load),
    .load_data (rd_data),
    .word      (ser_word),
    .stat      (ser_stat)
  );

`ifndef SYNTHESIS
  a_ack_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == csml_pkg::KIND_ACK) |->
      (shift_word == '0) && (word_number == '0) && !last_word)
    else $error("acknowledge carries shift word fields");

  a_word_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == csml_pkg::KIND_WORD) |-> !accepted && !pending)
    else $error("shift word transaction carries acknowledge fields");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    strobe && last_word |->
      (kind == csml_pkg::KIND_WORD) && (word_number == 6'(MAP_WORDS - 1)))
    else $error("last word marked at wrong position");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  a_shift_active: assert property (@(posedge clk) disable iff (rst)
    (state == csml_pkg::ST_SHIFT) && !ser_stat.done |-> ser_stat.active)
    else $error("serializer idle while waiting for a word");
`endif

endmodule

// File: sv/csml_map_mem.sv
// ----------------------------------------------------------------------------
// csml_map_mem
// Switch map storage: one word per entry, registered read, per-entry valid
// bits so that reset and clear-all empty the map at once.
// ----------------------------------------------------------------------------
module csml_map_mem #(
  parameter int DEPTH = csml_pkg::WORD_W * csml_pkg::CHIP_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  csml_pkg::map_ctl_t          ctl,
  input  logic [AW-1:0]               rd_addr,
  input  logic [AW-1:0]               wr_addr,
  input  logic [csml_pkg::WORD_W-1:0] wr_data,
  output logic [csml_pkg::WORD_W-1:0] rd_data
);

  logic [csml_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid;
  logic [csml_pkg::WORD_W-1:0] rd_word;
  logic                        rd_hit;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        valid <= '0;
      end else if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_data = rd_hit ? rd_word : '0;

endmodule

// File: sv/csml_serializer.sv
// ----------------------------------------------------------------------------
// csml_serializer
// Shifts one map word out MSB first, one bit per cycle, and collects the bit
// stream back into the word that goes out with the result.
// ----------------------------------------------------------------------------
module csml_serializer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [csml_pkg::WORD_W-1:0] load_data,
  output logic [csml_pkg::WORD_W-1:0] word,
  output csml_pkg::ser_stat_t         stat
);

  localparam int CW = $clog2(csml_pkg::WORD_W + 1);

  logic [csml_pkg::WORD_W-1:0] shreg;
  logic [csml_pkg::WORD_W-1:0] collect;
  logic [CW-1:0]               bits_left;
  logic                        done;

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= load_data;
    end else if (bits_left != '0) begin
      shreg   <= {shreg[csml_pkg::WORD_W-2:0], 1'b0};
      collect <= {collect[csml_pkg::WORD_W-2:0], shreg[csml_pkg::WORD_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
      done      <= 1'b0;
    end else begin
      done <= (bits_left == CW'(1)) && !load;
      if (load) begin
        bits_left <= CW'(csml_pkg::WORD_W);
      end else if (bits_left != '0) begin
        bits_left <= bits_left - 1'b1;
      end
    end
  end

  assign word        = collect;
  assign stat.active = (bits_left != '0);
  assign stat.done   = done;

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives connect, clear-all and update commands into the crosspoint switch
// map loader, tracks the switch map and pending flag alongside it, and checks
// every acknowledge and shift word against the tracked state.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHIP_COUNT = csml_pkg::CHIP_COUNT_DEF;
  localparam int MAP_WORDS  = csml_pkg::SIG_COUNT * CHIP_COUNT;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 480;

  typedef struct packed {
    logic        kind;
    logic        accepted;
    logic        pending;
    logic [15:0] word;
    logic [5:0]  number;
    logic        last;
  } switch_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = csml_pkg::ACT_CONNECT;
  logic [5:0]  pin_number = '0;
  logic [4:0]  bus_signal = '0;
  logic        busy;
  logic        strobe;
  logic        kind;
  logic        accepted;
  logic        pending;
  logic [15:0] shift_word;
  logic [5:0]  word_number;
  logic        last_word;

  logic [15:0]    map_shadow [MAP_WORDS];
  logic           pending_shadow;
  switch_result_t awaited_results [$];
  int             mismatch_count = 0;
  int             items_sent = 0;
  bit             no_gaps = 1'b0;

  crosspoint_switch_map_loader_core #(.CHIP_COUNT(CHIP_COUNT)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .pin_number(pin_number), .bus_signal(bus_signal),
    .strobe(strobe), .kind(kind), .accepted(accepted), .pending(pending),
    .shift_word(shift_word), .word_number(word_number), .last_word(last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

  // Apply one issued command to the shadow map and queue its results.
  function automatic void predict_switch_results(logic [1:0] act, logic [5:0] pin,
                                                 logic [4:0] sig);
    switch_result_t r;
    int chip;
    int word_idx;
    r = '0;
    unique case (act)
      csml_pkg::ACT_CONNECT: begin
        r.kind = csml_pkg::KIND_ACK;
        if (pin < MAP_WORDS && sig < csml_pkg::SIG_COUNT) begin
          chip = pin / csml_pkg::SIG_COUNT;
          word_idx = (CHIP_COUNT - 1 - chip) * csml_pkg::SIG_COUNT
                     + (csml_pkg::SIG_COUNT - 1 - sig);
          map_shadow[word_idx][pin % csml_pkg::SIG_COUNT] = 1'b1;
          pending_shadow = 1'b1;
          r.accepted = 1'b1;
        end
        r.pending = pending_shadow;
        awaited_results.push_back(r);
      end
      csml_pkg::ACT_CLEAR: begin
        foreach (map_shadow[i]) map_shadow[i] = '0;
        pending_shadow = 1'b1;
        r.kind = csml_pkg::KIND_ACK;
        r.accepted = 1'b1;
        r.pending = 1'b1;
        awaited_results.push_back(r);
      end
      csml_pkg::ACT_UPDATE: begin
        pending_shadow = 1'b0;
        for (int i = 0; i < MAP_WORDS; i++) begin
          r = '0;
          r.kind = csml_pkg::KIND_WORD;
          r.word = map_shadow[i];
          r.number = 6'(i);
          r.last = (i == MAP_WORDS - 1);
          awaited_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_checker
    switch_result_t want;
    if (!rst && strobe) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d word %h",
                 $time, kind, shift_word);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", want.kind, kind);
        check_field("accepted", want.accepted, accepted);
        check_field("pending", want.pending, pending);
        check_field("shift_word", want.word, shift_word);
        check_field("word_number", want.number, word_number);
        check_field("last_word", want.last, last_word);
      end
    end
  end

  // Leaves start high; the caller either sends again or drops it.
  task automatic send_command(input logic [1:0] act, input logic [5:0] pin,
                              input logic [4:0] sig);
    start <= 1'b1;
    action <= act;
    pin_number <= pin;
    bus_signal <= sig;
    do @(posedge clk); while (busy);
    predict_switch_results(act, pin, sig);
  endtask

  task automatic issue(input logic [1:0] act, input logic [5:0] pin,
                       input logic [4:0] sig);
    int gap;
    send_command(act, pin, sig);
    if (act != ACT_UNUSED) items_sent++;
    if (!no_gaps && $urandom_range(99) < 37) begin
      gap = $urandom_range(1, 5);
      if ($urandom_range(9) == 0) gap = $urandom_range(6, 40);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained;
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_connect_corners;
    issue(csml_pkg::ACT_CONNECT, 6'd0, 5'd0);
    issue(csml_pkg::ACT_CONNECT, 6'd15, 5'd15);
    issue(csml_pkg::ACT_CONNECT, 6'd16, 5'd0);
    issue(csml_pkg::ACT_CONNECT, 6'd31, 5'd7);
    issue(csml_pkg::ACT_CONNECT, 6'd32, 5'd15);
    issue(csml_pkg::ACT_CONNECT, 6'd47, 5'd15);
    issue(csml_pkg::ACT_CONNECT, 6'd47, 5'd0);
    issue(csml_pkg::ACT_CONNECT, 6'd0, 5'd0);   // bit already set
    issue(csml_pkg::ACT_UPDATE, 6'd0, 5'd0);
  endtask

  task automatic test_rejected_connects;
    issue(csml_pkg::ACT_CONNECT, 6'd48, 5'd0);
    issue(csml_pkg::ACT_CONNECT, 6'd63, 5'd31);
    issue(csml_pkg::ACT_CONNECT, 6'd0, 5'd16);
    issue(csml_pkg::ACT_CONNECT, 6'd47, 5'd31);
    issue(csml_pkg::ACT_CONNECT, 6'd21, 5'd16);
  endtask

  task automatic test_unused_action;
    issue(ACT_UNUSED, 6'd63, 5'd31);
    issue(ACT_UNUSED, 6'd0, 5'd0);
  endtask

  task automatic test_update_repeat;
    issue(csml_pkg::ACT_UPDATE, 6'd63, 5'd31);
    issue(csml_pkg::ACT_UPDATE, 6'd0, 5'd0);    // nothing pending
  endtask

  task automatic test_clear_then_update;
    issue(csml_pkg::ACT_CLEAR, 6'd0, 5'd0);
    issue(csml_pkg::ACT_UPDATE, 6'd0, 5'd0);
    issue(csml_pkg::ACT_CONNECT, 6'd10, 5'd3);
    issue(csml_pkg::ACT_UPDATE, 6'd0, 5'd0);
  endtask

  task automatic test_drain_pause;
    issue(csml_pkg::ACT_CONNECT, 6'd33, 5'd9);
    hold_until_drained();
    issue(csml_pkg::ACT_UPDATE, 6'd0, 5'd0);
    hold_until_drained();
  endtask

  // Mostly connect runs closed by an update, with clears and random noise.
  task automatic test_random_sequences;
    int goal;
    int pick;
    int run_len;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      no_gaps = (items_sent > goal - 300) && (items_sent < goal - 200);
      pick = $urandom_range(99);
      if (pick < 15) begin
        issue(2'($urandom_range(3)), 6'($urandom_range(63)), 5'($urandom_range(31)));
      end else if (pick < 20) begin
        issue(csml_pkg::ACT_CLEAR, 6'($urandom_range(63)), 5'($urandom_range(31)));
      end else if (pick < 23) begin
        hold_until_drained();
      end else begin
        run_len = $urandom_range(1, 10);
        repeat (run_len) begin
          if ($urandom_range(9) == 0)
            issue(csml_pkg::ACT_CONNECT, 6'($urandom_range(63)),
                  5'($urandom_range(31)));
          else
            issue(csml_pkg::ACT_CONNECT, 6'($urandom_range(MAP_WORDS - 1)),
                  5'($urandom_range(csml_pkg::SIG_COUNT - 1)));
        end
        issue(csml_pkg::ACT_UPDATE, 6'($urandom_range(63)), 5'($urandom_range(31)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (map_shadow[i]) map_shadow[i] = '0;
    pending_shadow = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_connect_corners();
    test_rejected_connects();
    test_unused_action();
    test_update_repeat();
    test_clear_then_update();
    test_drain_pause();
    test_random_sequences();
    hold_until_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
